@@ rtl/binarize_and_mark_contour_defines.svh @@
// Assertion macros for the binarize_and_mark_contour block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BINARIZE_AND_MARK_CONTOUR_DEFINES_SVH
`define BINARIZE_AND_MARK_CONTOUR_DEFINES_SVH

`ifndef ASSERT_OFF

`define BMC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define BMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BMC_ASSERT_IMPLY(lbl, ante, cons)

`define BMC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/bmc_pkg.sv @@
// Shared types and constants for the binarize_and_mark_contour block.
// No dependencies.
package bmc_pkg;

    localparam int CHAN_W         = 8;
    localparam int THR_W          = 8;
    localparam int SIZE_W         = 12;
    localparam int COORD_W        = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int IN_TDATA_W     = 24;
    localparam int OUT_TDATA_W    = 24;
    localparam int WIN_W          = 9;
    localparam int QUEUE_DEPTH    = 2;
    localparam int MIN_SIZE       = 3;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int THRESHOLD_RST  = 128;
    localparam int WIDTH_RST      = 640;
    localparam int HEIGHT_RST     = 480;

    // all window positions except the center
    localparam logic [WIN_W-1:0] NEIGHBOR_MASK = 9'h1EF;
    localparam int               CENTER_BIT    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic               emit;
        logic               done;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } bmc_tag_t;

    localparam int TAG_W = $bits(bmc_tag_t);

    typedef struct packed {
        logic full;
        logic empty;
    } bmc_qstat_t;

endpackage

@@ rtl/binarize_and_mark_contour.sv @@
// Top level of the binarize_and_mark_contour block.
// Depends on bmc_pkg, bmc_front, bmc_queue, bmc_back and the defines header.
//
// Usage:
//   s_* carries raster-scan RGB pixels, one per item. Each pixel is white if
//   any channel exceeds the threshold. For every interior pixel (r,c) one item
//   leaves on m_* once pixel (r+1,c+1) has been accepted; border pixels give
//   none. m_tuser is set for a black pixel with a white 8-neighbor, m_tlast on
//   the last interior pixel of the frame.
//   cfg_* writes threshold (0), frame width (1) or frame height (2); sizes are
//   clamped to [3, MAX]. It is always ready; the user must write it only
//   while idle, which the block itself does not enforce. Throughput: one
//   pixel per cycle while m_tready is high. The result passes through the
//   queue, line store read and output register once (r+1,c+1) is accepted.
//   Reset clears position to row 0, column 0, the window to black and loads
//   threshold 128, 640 x 480. Line store contents are not cleared; rows 0 and
//   1 of the first frame fill them before any result uses them.
//   When m_tready is low the output register holds; the 2-entry queue and the
//   line store stage absorb up to three more pixels before s_tready drops.
`include "binarize_and_mark_contour_defines.svh"

module binarize_and_mark_contour
    import bmc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // chan_zero, chan_one, chan_two
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // out_row, out_col, 2'b0 pad
    output logic                   m_tuser,   // is_contour
    output logic                   m_tlast,   // frame_done
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SIZE_W-1:0]      cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = TAG_W + CW + 1;

    logic          push, pop;
    logic          push_bit;
    logic [CW-1:0] push_addr;
    bmc_tag_t      push_tag;
    logic [QW-1:0] q_wr_data, q_rd_data;
    bmc_qstat_t    q_stat;
    logic          q_bit;
    logic [CW-1:0] q_addr;
    bmc_tag_t      q_tag;

    assign cfg_ready = 1'b1;

    bmc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_bit  (push_bit),
        .push_addr (push_addr),
        .push_tag  (push_tag)
    );

    assign q_wr_data = {push_tag, push_addr, push_bit};

    bmc_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (q_wr_data),
        .pop     (pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    assign q_bit  = q_rd_data[0];
    assign q_addr = q_rd_data[CW:1];
    assign q_tag  = q_rd_data[QW-1:CW+1];

    bmc_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (!q_stat.empty),
        .pop      (pop),
        .q_bit    (q_bit),
        .q_addr   (q_addr),
        .q_tag    (q_tag),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `BMC_ASSERT_IMPLY(a_pop_has_data, pop, !q_stat.empty)
    `BMC_ASSERT_NEXT(a_push_fills, push, !q_stat.empty)
    `BMC_ASSERT_IMPLY(a_no_overrun, q_stat.full, !push)

endmodule

@@ rtl/bmc_front.sv @@
// Front end: configuration registers, pixel threshold and raster position.
// Classifies each accepted pixel and pushes it to the queue. Uses bmc_pkg.
module bmc_front
    import bmc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [SIZE_W-1:0]            cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [IN_TDATA_W-1:0]        s_tdata,
    input  bmc_qstat_t                   q_stat,
    output logic                         push,
    output logic                         push_bit,
    output logic [$clog2(MAX_WIDTH)-1:0] push_addr,
    output bmc_tag_t                     push_tag
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int EW  = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
    localparam int EH  = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;
    localparam int RXW = (RW > COORD_W) ? RW : COORD_W;
    localparam int CXW = (CW > COORD_W) ? CW : COORD_W;
    localparam logic [EW-1:0] WIDTH_RST_CL =
        EW'((WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST);
    localparam logic [EH-1:0] HEIGHT_RST_CL =
        EH'((HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST);

    logic [THR_W-1:0] thr_reg, thr_next;
    logic [EW-1:0]    width_reg, width_next;
    logic [EH-1:0]    height_reg, height_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;

    logic [EW-1:0]    size_w_in, width_cl, col_inc;
    logic [EH-1:0]    size_h_in, height_cl, row_inc;
    logic [RXW-1:0]   row_m1;
    logic [CXW-1:0]   col_m1;
    logic [CHAN_W-1:0] chan_zero, chan_one, chan_two;
    logic             row_wrap;

    assign chan_zero = s_tdata[CHAN_W-1:0];
    assign chan_one  = s_tdata[2*CHAN_W-1:CHAN_W];
    assign chan_two  = s_tdata[3*CHAN_W-1:2*CHAN_W];

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        size_w_in = EW'(cfg_data);
        size_h_in = EH'(cfg_data);
        if (size_w_in < EW'(MIN_SIZE))
            width_cl = EW'(MIN_SIZE);
        else if (size_w_in > EW'(MAX_WIDTH))
            width_cl = EW'(MAX_WIDTH);
        else
            width_cl = size_w_in;
        if (size_h_in < EH'(MIN_SIZE))
            height_cl = EH'(MIN_SIZE);
        else if (size_h_in > EH'(MAX_HEIGHT))
            height_cl = EH'(MAX_HEIGHT);
        else
            height_cl = size_h_in;

        thr_next    = thr_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD: thr_next    = cfg_data[THR_W-1:0];
                CFG_WIDTH:     width_next  = width_cl;
                CFG_HEIGHT:    height_next = height_cl;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        col_inc  = EW'(col_reg) + EW'(1);
        row_inc  = EH'(row_reg) + EH'(1);
        row_wrap = (col_inc >= width_reg);
        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (row_wrap)
            begin
                col_next = '0;
                row_next = (row_inc >= height_reg) ? '0 : row_inc[RW-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end

        row_m1 = RXW'(row_reg) - RXW'(1);
        col_m1 = CXW'(col_reg) - CXW'(1);

        push_bit       = (chan_zero > thr_reg) || (chan_one > thr_reg) ||
                         (chan_two > thr_reg);
        push_addr      = col_reg;
        push_tag.emit  = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
        push_tag.done  = (row_inc == height_reg) && (col_inc == width_reg);
        push_tag.row   = row_m1[COORD_W-1:0];
        push_tag.col   = col_m1[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THR_W'(THRESHOLD_RST);
            width_reg  <= WIDTH_RST_CL;
            height_reg <= HEIGHT_RST_CL;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            thr_reg    <= thr_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

@@ rtl/bmc_queue.sv @@
// Small FIFO between the front end and the back end.
// Generic width and depth. Uses bmc_pkg for the status struct.
module bmc_queue
    import bmc_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output bmc_qstat_t       stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign rd_data    = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == NW'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + NW'(1);
        else if (pop && !push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ rtl/bmc_back.sv @@
// Back end: line store, 3x3 window, contour test and output register.
// Drains the queue one item per cycle while not stalled. Uses bmc_pkg.
module bmc_back
    import bmc_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         pop,
    input  logic                         q_bit,
    input  logic [$clog2(MAX_WIDTH)-1:0] q_addr,
    input  bmc_tag_t                     q_tag,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [OUT_TDATA_W-1:0]       m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);

    // line store entry: bit 1 = row above, bit 0 = two rows above
    logic [1:0]       line_mem [MAX_WIDTH];
    logic [1:0]       rd_reg;

    logic             a_valid_reg, a_valid_next;
    logic             a_bit_reg;
    logic [CW-1:0]    a_addr_reg;
    bmc_tag_t         a_tag_reg;
    logic             a_adv;

    logic [WIN_W-1:0] win_reg, win_next;
    logic             contour;

    logic             out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] out_row_reg, out_col_reg;
    logic             out_contour_reg, out_done_reg;

    assign a_adv = a_valid_reg && (!a_tag_reg.emit || !out_valid_reg || m_tready);
    assign pop   = q_valid && (!a_valid_reg || a_adv);

    always_comb
    begin
        win_next = {win_reg[WIN_W-4:0], a_bit_reg, rd_reg[1], rd_reg[0]};
        contour  = !win_next[CENTER_BIT] && ((win_next & NEIGHBOR_MASK) != '0);

        a_valid_next = a_valid_reg;
        if (pop)
            a_valid_next = 1'b1;
        else if (a_adv)
            a_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (a_adv && a_tag_reg.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            if (a_adv)
                win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_bit_reg  <= q_bit;
            a_addr_reg <= q_addr;
            a_tag_reg  <= q_tag;
        end
        if (a_adv && a_tag_reg.emit)
        begin
            out_row_reg     <= a_tag_reg.row;
            out_col_reg     <= a_tag_reg.col;
            out_contour_reg <= contour;
            out_done_reg    <= a_tag_reg.done;
        end
    end

    // same address is revisited only a full row later
    always_ff @(posedge clk)
    begin
        if (pop)
            rd_reg <= line_mem[q_addr];
        if (a_adv)
            line_mem[a_addr_reg] <= {a_bit_reg, rd_reg[1]};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - 2 * COORD_W)'(0), out_col_reg, out_row_reg};
    assign m_tuser  = out_contour_reg;
    assign m_tlast  = out_done_reg;

endmodule

@@ tb/sv/contour_result_checker.sv @@
// Checker for binarize_and_mark_contour: follows the pixel, result and register
// channels, predicts the contour mark of every interior pixel and compares.
// Depends on bmc_pkg.
module contour_result_checker
    import bmc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // chan_zero, chan_one, chan_two
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // out_row, out_col, 2'b0 pad
    input  logic                   m_tuser,   // is_contour
    input  logic                   m_tlast,   // frame_done
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SIZE_W-1:0]      cfg_data,
    output int                     fails,
    output int                     outstanding,
    output logic                   frame_start
);

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               contour;
        logic               done;
    } mark_t;

    mark_t             pending_marks [$];
    logic              upper_bits  [DEF_MAX_WIDTH];
    logic              middle_bits [DEF_MAX_WIDTH];
    logic [WIN_W-1:0]  window;
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [THR_W-1:0]  thr;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    assign frame_start = (row_pos == 0) && (col_pos == 0);

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic predict_contour(input logic [IN_TDATA_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        logic        white;
        logic        up;
        logic        mid;
        mark_t       mark;
        w = clamp_size(width_reg, DEF_MAX_WIDTH);
        h = clamp_size(height_reg, DEF_MAX_HEIGHT);
        r = row_pos;
        c = col_pos;
        white = (px[CHAN_W-1:0] > thr) || (px[2*CHAN_W-1:CHAN_W] > thr)
             || (px[3*CHAN_W-1:2*CHAN_W] > thr);
        up  = 1'b0;
        mid = 1'b0;
        if (c < DEF_MAX_WIDTH)
        begin
            up  = upper_bits[c];
            mid = middle_bits[c];
            upper_bits[c]  = mid;
            middle_bits[c] = white;
        end
        // newest column in the low bits: top, middle, bottom
        window = {window[WIN_W-4:0], white, mid, up};
        if (r >= 2 && c >= 2)
        begin
            mark.row     = COORD_W'(r - 1);
            mark.col     = COORD_W'(c - 1);
            mark.contour = !window[CENTER_BIT] && ((window & NEIGHBOR_MASK) != '0);
            mark.done    = (r == h - 1) && (c == w - 1);
            pending_marks.insert(pending_marks.size(), mark);
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mark_t got;
        mark_t want;
        if (!rst_n)
        begin
            pending_marks.delete();
            for (int i = 0; i < DEF_MAX_WIDTH; i++)
            begin
                upper_bits[i]  = 1'b0;
                middle_bits[i] = 1'b0;
            end
            window      = '0;
            row_pos     = 0;
            col_pos     = 0;
            thr         = THR_W'(THRESHOLD_RST);
            width_reg   = SIZE_W'(WIDTH_RST);
            height_reg  = SIZE_W'(HEIGHT_RST);
            fails       = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_THRESHOLD: thr        = cfg_data[THR_W-1:0];
                    CFG_WIDTH:     width_reg  = cfg_data;
                    CFG_HEIGHT:    height_reg = cfg_data;
                    default:       ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_contour(s_tdata);
            if (m_tvalid && m_tready)
            begin
                got.row     = m_tdata[COORD_W-1:0];
                got.col     = m_tdata[2*COORD_W-1:COORD_W];
                got.contour = m_tuser;
                got.done    = m_tlast;
                if (pending_marks.size() == 0)
                begin
                    fails++;
                    $display("%0t: expected no item, got row %0d col %0d contour %0b done %0b",
                             $time, got.row, got.col, got.contour, got.done);
                end
                else
                begin
                    want = pending_marks.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        $display("%0t: expected row %0d col %0d contour %0b done %0b",
                                 $time, want.row, want.col, want.contour, want.done);
                        $display("%0t:      got row %0d col %0d contour %0b done %0b",
                                 $time, got.row, got.col, got.contour, got.done);
                    end
                end
            end
            outstanding = pending_marks.size();
        end
    end

endmodule

@@ tb/sv/binarize_and_mark_contour_test.sv @@
// Top of the binarize_and_mark_contour testbench: drives pixels, register
// writes and output stalls, and reports the verdict of contour_result_checker.
// Depends on bmc_pkg, binarize_and_mark_contour and contour_result_checker.
module binarize_and_mark_contour_test;
    import bmc_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_GAP     = 8;
    localparam int ITEMS_PER_MODE = 315;

    // 3x3 frame: black center at threshold 128, mixed white and black neighbors
    localparam logic [IN_TDATA_W-1:0] RING_PX [9] = '{
        24'hFFFFFF, 24'h000000, 24'h808080,
        24'h000000, 24'h807F80, 24'h810000,
        24'h008100, 24'h000081, 24'h000000
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [SIZE_W-1:0]      cfg_data;

    int                     fails;
    int                     outstanding;
    logic                   frame_start;
    int unsigned            snd_idle_pct;
    int unsigned            rcv_idle_pct;
    logic                   hold_req;
    int                     cycles = 0;
    int unsigned            items_sent;
    logic [THR_W-1:0]       cur_thr;
    logic [SIZE_W-1:0]      cur_w;
    logic [SIZE_W-1:0]      cur_h;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    binarize_and_mark_contour uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    contour_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fails       (fails),
        .outstanding (outstanding),
        .frame_start (frame_start)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("binarize_and_mark_contour_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [SIZE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_THRESHOLD: cur_thr = val[THR_W-1:0];
            CFG_WIDTH:     cur_w   = val;
            default:       cur_h   = val;
        endcase
    endtask

    task automatic send_pixel(input logic [IN_TDATA_W-1:0] px);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    // block idle: all results out and the pipeline drained
    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_GAP) @(negedge clk);
    endtask

    function automatic logic [IN_TDATA_W-1:0] make_pixel(int unsigned dark_pct);
        logic [CHAN_W-1:0] ch [3];
        int unsigned       pick;
        pick = $urandom_range(99);
        for (int i = 0; i < 3; i++)
            ch[i] = CHAN_W'($urandom_range(cur_thr));
        if (pick >= 90)
        begin
            for (int i = 0; i < 3; i++)
                ch[i] = CHAN_W'($urandom());
        end
        else if (pick >= dark_pct && cur_thr != 8'hFF)
        begin
            ch[$urandom_range(2)] = CHAN_W'($urandom_range(255, cur_thr + 1));
        end
        return {ch[2], ch[1], ch[0]};
    endfunction

    // runs to the end of the current frame; with cut > 0 the width may shrink or
    // the height may change after that many pixels
    task automatic random_frame(input int unsigned cut);
        int unsigned dark_pct;
        int unsigned sent;
        dark_pct = $urandom_range(85, 15);
        sent = 0;
        do
        begin
            send_pixel(make_pixel(dark_pct));
            sent++;
            if (cut != 0 && sent == cut && !frame_start)
            begin
                settle();
                if ($urandom_range(1))
                    write_reg(CFG_WIDTH, SIZE_W'($urandom_range(cur_w)));
                else
                    write_reg(CFG_HEIGHT, SIZE_W'($urandom_range(10)));
            end
        end
        while (!frame_start);
    endtask

    task automatic pick_settings();
        logic [THR_W-1:0] t;
        settle();
        if ($urandom_range(2) == 0)
        begin
            case ($urandom_range(5))
                0:       t = 8'h00;
                1:       t = 8'hFF;
                default: t = THR_W'($urandom());
            endcase
            write_reg(CFG_THRESHOLD, {4'($urandom()), t});
        end
        if ($urandom_range(1))
            write_reg(CFG_WIDTH, SIZE_W'($urandom_range(12)));
        if ($urandom_range(1))
            write_reg(CFG_HEIGHT, SIZE_W'($urandom_range(8)));
    endtask

    initial
    begin
        int unsigned mode_start;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_THRESHOLD;
        cfg_data     = '0;
        hold_req     = 1'b0;
        snd_idle_pct = 9;
        rcv_idle_pct = 87;
        items_sent   = 0;
        cur_thr      = THR_W'(THRESHOLD_RST);
        cur_w        = SIZE_W'(WIDTH_RST);
        cur_h        = SIZE_W'(HEIGHT_RST);
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // isolated black center; sizes below minimum, threshold upper bits masked
        write_reg(CFG_THRESHOLD, 12'hF00);
        write_reg(CFG_WIDTH, 12'd0);
        write_reg(CFG_HEIGHT, 12'd2);
        repeat (9) send_pixel(24'h000000);

        settle();
        write_reg(CFG_THRESHOLD, 12'hA80);
        foreach (RING_PX[i])
            send_pixel(RING_PX[i]);

        // white center among black
        settle();
        write_reg(CFG_THRESHOLD, 12'h0FE);
        repeat (4) send_pixel(24'h000000);
        send_pixel(24'hFF0000);
        repeat (4) send_pixel(24'h000000);

        // widest row, narrowed mid-row
        settle();
        write_reg(CFG_WIDTH, 12'hFFF);
        repeat (4) send_pixel(make_pixel(50));
        settle();
        write_reg(CFG_WIDTH, 12'd1);
        random_frame(0);

        // tallest frame, cut below the current row
        settle();
        write_reg(CFG_HEIGHT, 12'hFFF);
        repeat (15) send_pixel(make_pixel(50));
        settle();
        write_reg(CFG_HEIGHT, 12'd0);
        random_frame(0);

        for (int mode = 0; mode < 3; mode++)
        begin
            snd_idle_pct = (mode == 0) ? 9 : (mode == 1) ? 87 : 0;
            rcv_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 9 : 0;
            mode_start = items_sent;
            if (mode == 2)
            begin
                settle();
                write_reg(CFG_WIDTH, 12'd12);
                write_reg(CFG_HEIGHT, 12'd8);
                hold_req = 1'b1;
                random_frame(0);
            end
            while (items_sent - mode_start < ITEMS_PER_MODE)
            begin
                pick_settings();
                random_frame(($urandom_range(4) == 0) ? $urandom_range(30, 1) : 0);
            end
        end

        settle();
        if (fails == 0)
            $display("binarize_and_mark_contour_test: done, clean");
        else
            $display("binarize_and_mark_contour_test: done, errors");
        $finish;
    end

endmodule

@@ binarize_and_mark_contour.f @@
+incdir+rtl
rtl/bmc_pkg.sv
rtl/bmc_front.sv
rtl/bmc_queue.sv
rtl/bmc_back.sv
rtl/binarize_and_mark_contour.sv
tb/sv/contour_result_checker.sv
tb/sv/binarize_and_mark_contour_test.sv
